>>> rtl/core/aoc_pkg.sv
// Package for the alphabet odometer counter: field widths, command, event and
// register codes, and the request/result types of the shared divider.
// No dependencies.
package aoc_pkg;

   localparam int AMOUNT_W    = 32;
   localparam int DIGIT_W     = 8;
   localparam int RADIX_W     = 9;
   localparam int LENGTH_W    = 5;
   localparam int POS_W       = 4;
   localparam int CMD_W       = 2;
   localparam int EVENT_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int OUT_CAP     = 16;

   localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SUB  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

   localparam logic [EVENT_W-1:0] EV_NORMAL = 2'd0;
   localparam logic [EVENT_W-1:0] EV_WRAP   = 2'd1;
   localparam logic [EVENT_W-1:0] EV_STOP   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_LENGTH  = 2'd1;

   typedef struct packed {
      logic                start;
      logic [AMOUNT_W-1:0] dividend;
      logic [RADIX_W-1:0]  divisor;
   } aoc_div_req_type;

   typedef struct packed {
      logic                done;
      logic [AMOUNT_W-1:0] quotient;
      logic [RADIX_W-1:0]  remainder;
   } aoc_div_res_type;

endpackage

>>> rtl/core/alphabet_odometer_counter_top.sv
// Alphabet odometer counter top level: sequencer, digit register file, output register.
// Depends on aoc_pkg, aoc_div and aoc_table.
//
// Usage: requests arrive on req_* (valid/ready). An add or subtract request
// produces one rsp_* result per digit position in use, position 0 first,
// rsp_last on the final one. A load request writes one alphabet entry and
// produces nothing. csr_* writes symbol_count (index 0) and word_length
// (index 1); write only while idle.
// Per digit position, the shared divider first reduces a stored digit that is not
// below the radix, then splits off the next digit part when the remaining amount
// is nonzero. Each result is then read from the table (S_EMIT_RD) and loaded into
// the output register (S_EMIT_LD) once that register is free.
// req_ready is high only while the sequencer is idle; a request can be taken
// while the final result still waits in the output register.
// Reset: digits clear to zero, symbol_count 2, word_length 1; the alphabet
// table is undefined until loaded.
// A stalled receiver holds the current result and the sequencer waits.
module alphabet_odometer_counter_top
   import aoc_pkg::*;
#(
   parameter int MAX_LEN     = 16,
   parameter int MAX_SYMBOLS = 256
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [AMOUNT_W-1:0]    req_amount,
   input  logic [7:0]             req_entry_index,
   input  logic [7:0]             req_entry_symbol,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [POS_W-1:0]       rsp_position,
   output logic [DIGIT_W-1:0]     rsp_digit,
   output logic [DIGIT_W-1:0]     rsp_symbol,
   output logic [EVENT_W-1:0]     rsp_event_res,
   output logic                   rsp_last,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RADIX_W-1:0]     csr_write_data
);

   localparam int LEN_CAP = (MAX_LEN < OUT_CAP) ? MAX_LEN : OUT_CAP;
   localparam int LEN_IW  = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
   localparam int SYM_IW  = $clog2(MAX_SYMBOLS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_RWAIT,
      S_PART,
      S_PWAIT,
      S_APPLY,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   state_type              state_ff;
   logic [RADIX_W-1:0]     symbol_count_ff;
   logic [LENGTH_W-1:0]    word_length_ff;
   logic [DIGIT_W-1:0]     digits_ff [LEN_CAP];
   logic                   is_sub_ff;
   logic [AMOUNT_W-1:0]    rem_ff;
   logic                   carry_ff;
   logic [LEN_IW-1:0]      idx_ff;
   logic [DIGIT_W-1:0]     dval_ff;
   logic [DIGIT_W-1:0]     part_ff;
   logic [RADIX_W-1:0]     radix_ff;
   logic [LENGTH_W-1:0]    len_ff;
   logic [EVENT_W-1:0]     event_ff;
   logic [DIGIT_W-1:0]     emit_dig_ff;
   logic                   rsp_valid_ff;
   logic [POS_W-1:0]       rsp_position_ff;
   logic [DIGIT_W-1:0]     rsp_digit_ff;
   logic [DIGIT_W-1:0]     rsp_symbol_ff;
   logic [EVENT_W-1:0]     rsp_event_ff;
   logic                   rsp_last_ff;

   logic                   accept_in;
   logic [RADIX_W-1:0]     radix_in;
   logic [LENGTH_W-1:0]    len_in;
   logic [LENGTH_W-1:0]    len_m1_in;
   logic [LENGTH_W-1:0]    cur_len_m1_in;
   logic [DIGIT_W-1:0]     cur_dig_in;
   logic [RADIX_W:0]       sum_in;
   logic                   add_ge_in;
   logic [RADIX_W-1:0]     sub_in;
   logic                   sub_ok_in;
   logic [DIGIT_W-1:0]     new_dig_in;
   logic                   carry_in;
   logic [DIGIT_W-1:0]     emit_dig_in;
   logic                   out_free_in;
   logic                   is_last_in;
   logic                   tbl_wr_in;
   logic                   tbl_rd_in;
   logic [DIGIT_W-1:0]     tbl_rd_data;
   aoc_div_req_type        div_req;
   aoc_div_res_type        div_res;

   always_comb begin
      accept_in = req_valid && req_ready;

      radix_in = symbol_count_ff;
      if (radix_in > RADIX_W'(MAX_SYMBOLS)) radix_in = RADIX_W'(MAX_SYMBOLS);
      if (radix_in == '0) radix_in = RADIX_W'(1);

      len_in = word_length_ff;
      if (len_in > LENGTH_W'(LEN_CAP)) len_in = LENGTH_W'(LEN_CAP);
      if (len_in == '0) len_in = LENGTH_W'(1);
      len_m1_in     = len_in - LENGTH_W'(1);
      cur_len_m1_in = len_ff - LENGTH_W'(1);

      cur_dig_in = digits_ff[idx_ff];

      sum_in    = (RADIX_W+1)'(dval_ff) + (RADIX_W+1)'(part_ff) + (RADIX_W+1)'(carry_ff);
      add_ge_in = sum_in >= (RADIX_W+1)'(radix_ff);
      sub_in    = RADIX_W'(part_ff) + RADIX_W'(carry_ff);
      sub_ok_in = RADIX_W'(dval_ff) >= sub_in;

      if (!is_sub_ff) begin
         carry_in   = add_ge_in;
         new_dig_in = add_ge_in ? DIGIT_W'(sum_in - (RADIX_W+1)'(radix_ff))
                                : DIGIT_W'(sum_in);
      end else begin
         carry_in   = !sub_ok_in;
         new_dig_in = sub_ok_in ? DIGIT_W'(RADIX_W'(dval_ff) - sub_in)
                                : DIGIT_W'((RADIX_W+1)'(dval_ff) + (RADIX_W+1)'(radix_ff)
                                           - (RADIX_W+1)'(sub_in));
      end

      emit_dig_in = (event_ff == EV_STOP) ? '0 : cur_dig_in;
      out_free_in = !rsp_valid_ff || rsp_ready;
      is_last_in  = LENGTH_W'(idx_ff) == cur_len_m1_in;

      div_req.start    = 1'b0;
      div_req.dividend = rem_ff;
      div_req.divisor  = radix_ff;
      if (state_ff == S_REDUCE) begin
         div_req.start    = {1'b0, cur_dig_in} >= radix_ff;
         div_req.dividend = AMOUNT_W'(cur_dig_in);
      end else if (state_ff == S_PART) begin
         div_req.start = rem_ff != '0;
      end

      tbl_wr_in = accept_in && (req_cmd == CMD_LOAD)
                  && ({1'b0, req_entry_index} < RADIX_W'(MAX_SYMBOLS));
      tbl_rd_in = state_ff == S_EMIT_RD;
   end

   aoc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   aoc_table #(
      .DEPTH (MAX_SYMBOLS),
      .IW    (SYM_IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_in),
      .wr_addr (req_entry_index[SYM_IW-1:0]),
      .wr_data (req_entry_symbol),
      .rd_en   (tbl_rd_in),
      .rd_addr (emit_dig_in[SYM_IW-1:0]),
      .rd_data (tbl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         symbol_count_ff <= RADIX_W'(2);
         word_length_ff  <= LENGTH_W'(1);
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < LEN_CAP; i++) begin
            digits_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SYMBOL_COUNT: symbol_count_ff <= csr_write_data;
               CSR_WORD_LENGTH:  word_length_ff  <= csr_write_data[LENGTH_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready && state_ff != S_EMIT_LD) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept_in && (req_cmd == CMD_ADD || req_cmd == CMD_SUB)) begin
                  is_sub_ff <= req_cmd == CMD_SUB;
                  rem_ff    <= req_amount;
                  carry_ff  <= 1'b0;
                  radix_ff  <= radix_in;
                  len_ff    <= len_in;
                  idx_ff    <= len_m1_in[LEN_IW-1:0];
                  state_ff  <= S_REDUCE;
               end
            end
            S_REDUCE: begin
               dval_ff  <= cur_dig_in;
               state_ff <= div_req.start ? S_RWAIT : S_PART;
            end
            S_RWAIT: begin
               if (div_res.done) begin
                  dval_ff  <= div_res.remainder[DIGIT_W-1:0];
                  state_ff <= S_PART;
               end
            end
            S_PART: begin
               part_ff  <= '0;
               state_ff <= div_req.start ? S_PWAIT : S_APPLY;
            end
            S_PWAIT: begin
               if (div_res.done) begin
                  part_ff  <= div_res.remainder[DIGIT_W-1:0];
                  rem_ff   <= div_res.quotient;
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               digits_ff[idx_ff] <= new_dig_in;
               carry_ff          <= carry_in;
               if (idx_ff == '0) begin
                  if (carry_in || rem_ff != '0) begin
                     event_ff <= is_sub_ff ? EV_STOP : EV_WRAP;
                  end else begin
                     event_ff <= EV_NORMAL;
                  end
                  state_ff <= S_EMIT_RD;
               end else begin
                  idx_ff   <= idx_ff - LEN_IW'(1);
                  state_ff <= S_REDUCE;
               end
            end
            S_EMIT_RD: begin
               digits_ff[idx_ff] <= emit_dig_in;
               emit_dig_ff       <= emit_dig_in;
               state_ff          <= S_EMIT_LD;
            end
            S_EMIT_LD: begin
               if (out_free_in) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_position_ff <= POS_W'(idx_ff);
                  rsp_digit_ff    <= emit_dig_ff;
                  rsp_symbol_ff   <= tbl_rd_data;
                  rsp_event_ff    <= event_ff;
                  rsp_last_ff     <= is_last_in;
                  if (is_last_in) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + LEN_IW'(1);
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready     = state_ff == S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_digit     = rsp_digit_ff;
   assign rsp_symbol    = rsp_symbol_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> rtl/core/aoc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on aoc_pkg.
module aoc_div
   import aoc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  aoc_div_req_type div_req,
   output aoc_div_res_type div_res
);

   localparam int CNT_W = $clog2(AMOUNT_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [AMOUNT_W-1:0] quo_ff;
   logic [RADIX_W-1:0]  rem_ff;
   logic [RADIX_W-1:0]  div_ff;

   logic [RADIX_W:0]    trial_in;
   logic                fits_in;
   logic [RADIX_W:0]    diff_in;

   always_comb begin
      trial_in = {rem_ff, quo_ff[AMOUNT_W-1]};
      fits_in  = trial_in >= {1'b0, div_ff};
      diff_in  = trial_in - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && !div_req.start && (count_ff == CNT_W'(1));
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(AMOUNT_W);
            quo_ff   <= div_req.dividend;
            rem_ff   <= '0;
            div_ff   <= div_req.divisor;
         end else if (busy_ff) begin
            quo_ff   <= {quo_ff[AMOUNT_W-2:0], fits_in};
            rem_ff   <= fits_in ? diff_in[RADIX_W-1:0] : trial_in[RADIX_W-1:0];
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign div_res.done      = done_ff;
   assign div_res.quotient  = quo_ff;
   assign div_res.remainder = rem_ff;

endmodule

>>> rtl/core/aoc_table.sv
// Alphabet table memory: one write port, one registered read port.
// Depends on aoc_pkg.
module aoc_table
   import aoc_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int IW    = 8
)
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IW-1:0]      wr_addr,
   input  logic [DIGIT_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [IW-1:0]      rd_addr,
   output logic [DIGIT_W-1:0] rd_data
);

   logic [DIGIT_W-1:0] mem_ff [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> verif/tb_alphabet_odometer_counter_top.sv
// Self-checking testbench for alphabet_odometer_counter_top: directed table, then random
// phases. A behavioural odometer predicts each digit result; the results are checked in order.
// Depends on aoc_pkg and the RTL of alphabet_odometer_counter_top.
module tb_alphabet_odometer_counter_top
   import aoc_pkg::*;
();

   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
   localparam int NUM_SYMBOLS = 256;
   localparam int NUM_POS     = 16;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [DIGIT_W-1:0] digit;
      logic [DIGIT_W-1:0] symbol;
      logic [EVENT_W-1:0] event_res;
      logic               last_pos;
   } digit_result_type;

   typedef enum logic [1:0] {ROW_REQ, ROW_KNOWN, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CMD_W-1:0]     cmd;
      logic [AMOUNT_W-1:0]  amount;
      logic [7:0]           idx;
      logic [7:0]           sym;
      logic [RADIX_W-1:0]   radix;
      logic [LENGTH_W-1:0]  len;
      logic [EVENT_W-1:0]   ev;
      logic [DIGIT_W-1:0]   lsd;
   } drill_row_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_cmd          = CMD_ADD;
   logic [AMOUNT_W-1:0]    req_amount       = '0;
   logic [7:0]             req_entry_index  = '0;
   logic [7:0]             req_entry_symbol = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [POS_W-1:0]       rsp_position;
   logic [DIGIT_W-1:0]     rsp_digit;
   logic [DIGIT_W-1:0]     rsp_symbol;
   logic [EVENT_W-1:0]     rsp_event_res;
   logic                   rsp_last;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_SYMBOL_COUNT;
   logic [RADIX_W-1:0]     csr_write_data   = '0;

   digit_result_type    pending_digits[$];
   drill_row_type       drill_rows[$];
   logic [DIGIT_W-1:0]  odo_digits[NUM_POS];
   logic [7:0]          glyph_table[NUM_SYMBOLS];
   logic [RADIX_W-1:0]  radix_reg  = 9'd2;
   logic [LENGTH_W-1:0] length_reg = 5'd1;
   int unsigned         errors     = 0;
   int unsigned         burst_left = 0;
   int unsigned         pace_count = 0;
   int unsigned         pace_mode  = 0;

   alphabet_odometer_counter_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_amount       (req_amount),
      .req_entry_index  (req_entry_index),
      .req_entry_symbol (req_entry_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_digit        (rsp_digit),
      .rsp_symbol       (rsp_symbol),
      .rsp_event_res    (rsp_event_res),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   initial begin
      #60_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      for (int i = 0; i < NUM_POS; i++) odo_digits[i] = '0;
   end

   function automatic int unsigned radix_used();
      if (radix_reg == 0) return 1;
      if (radix_reg > NUM_SYMBOLS) return NUM_SYMBOLS;
      return 32'(radix_reg);
   endfunction

   function automatic int unsigned length_used();
      if (length_reg == 0) return 1;
      if (length_reg > NUM_POS) return NUM_POS;
      return 32'(length_reg);
   endfunction

   // Advance the predicted odometer for one accepted request and queue its results.
   // A known row replaces the event and the least significant digit with typed values.
   task automatic step_odometer(input logic [CMD_W-1:0] cmd, input logic [AMOUNT_W-1:0] amount,
                                input logic [7:0] idx, input logic [7:0] sym, input bit known,
                                input logic [EVENT_W-1:0] k_ev, input logic [DIGIT_W-1:0] k_lsd);
      int unsigned        radix;
      int unsigned        len;
      longint unsigned    rest;
      longint unsigned    part;
      longint unsigned    total;
      longint unsigned    carry;
      logic [EVENT_W-1:0] ev;
      digit_result_type   res;
      if (cmd == CMD_LOAD) begin
         glyph_table[idx] = sym;
         return;
      end
      if (cmd != CMD_ADD && cmd != CMD_SUB) return;
      radix = radix_used();
      len   = length_used();
      for (int i = 0; i < len; i++) odo_digits[i] = DIGIT_W'(odo_digits[i] % radix);
      rest  = {32'd0, amount};
      carry = 0;
      for (int k = len; k > 0; k--) begin
         part = rest % radix;
         rest = rest / radix;
         if (cmd == CMD_ADD) begin
            total = odo_digits[k-1] + part + carry;
            odo_digits[k-1] = DIGIT_W'(total % radix);
            carry = total / radix;
         end else begin
            total = part + carry;
            if (odo_digits[k-1] >= total) begin
               odo_digits[k-1] = DIGIT_W'(odo_digits[k-1] - total);
               carry = 0;
            end else begin
               odo_digits[k-1] = DIGIT_W'(odo_digits[k-1] + radix - total);
               carry = 1;
            end
         end
      end
      ev = EV_NORMAL;
      if (carry != 0 || rest != 0) begin
         if (cmd == CMD_ADD) begin
            ev = EV_WRAP;
         end else begin
            ev = EV_STOP;
            for (int i = 0; i < len; i++) odo_digits[i] = '0;
         end
      end
      for (int i = 0; i < len; i++) begin
         res.position  = POS_W'(i);
         res.digit     = odo_digits[i];
         res.event_res = known ? k_ev : ev;
         res.last_pos  = (i + 1 == len);
         if (known && i + 1 == len) res.digit = k_lsd;
         res.symbol    = glyph_table[res.digit];
         pending_digits.push_back(res);
      end
   endtask

   task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [AMOUNT_W-1:0] amount,
                                input logic [7:0] idx, input logic [7:0] sym, input bit known,
                                input logic [EVENT_W-1:0] k_ev, input logic [DIGIT_W-1:0] k_lsd);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_amount       <= amount;
      req_entry_index  <= idx;
      req_entry_symbol <= sym;
      do @(posedge clock); while (req_ready !== 1'b1);
      step_odometer(cmd, amount, idx, sym, known, k_ev, k_lsd);
   endtask

   // Hold off until every result is in, then let a load still in flight settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_config(input logic [RADIX_W-1:0] radix, input logic [LENGTH_W-1:0] len);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SYMBOL_COUNT;
      csr_write_data   <= radix;
      @(posedge clock);
      radix_reg = radix;
      csr_index        <= CSR_WORD_LENGTH;
      csr_write_data   <= {{(RADIX_W-LENGTH_W){1'b0}}, len};
      @(posedge clock);
      length_reg = len;
      csr_write_enable <= 1'b0;
   endtask

   function automatic void row(input row_kind_type kind, input logic [CMD_W-1:0] cmd,
                               input logic [AMOUNT_W-1:0] amount, input logic [7:0] idx,
                               input logic [7:0] sym, input logic [RADIX_W-1:0] radix,
                               input logic [LENGTH_W-1:0] len, input logic [EVENT_W-1:0] ev,
                               input logic [DIGIT_W-1:0] lsd);
      drill_row_type r;
      r.kind = kind;  r.cmd = cmd;   r.amount = amount;
      r.idx  = idx;   r.sym = sym;   r.radix  = radix;
      r.len  = len;   r.ev  = ev;    r.lsd    = lsd;
      drill_rows.push_back(r);
   endfunction

   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      if (errors < 40)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
      errors++;
   endtask

   always @(posedge clock) begin : result_check
      digit_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_digits.size() == 0) begin
            note_mismatch("unexpected result at position", 0, rsp_position);
         end else begin
            want = pending_digits.pop_front();
            if (rsp_position !== want.position)
               note_mismatch("position", want.position, rsp_position);
            if (rsp_digit !== want.digit)
               note_mismatch("digit", want.digit, rsp_digit);
            if (rsp_symbol !== want.symbol)
               note_mismatch("symbol", want.symbol, rsp_symbol);
            if (rsp_event_res !== want.event_res)
               note_mismatch("event", want.event_res, rsp_event_res);
            if (rsp_last !== want.last_pos)
               note_mismatch("last", want.last_pos, rsp_last);
         end
      end
   end

   // Receiver pacing: runs of always-ready, coin toss, mostly stalled and mostly ready.
   always @(posedge clock) begin
      if (pace_count == 0) begin
         pace_mode  <= $urandom_range(0, 3);
         pace_count <= $urandom_range(8, 60);
      end else begin
         pace_count <= pace_count - 1;
      end
      case (pace_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= (pace_count[1:0] == 2'd0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 5) != 0);
         end
      endcase
   end

   initial begin : stimulus
      int unsigned         sent;
      int unsigned         phase_items;
      int unsigned         pick;
      int unsigned         rv;
      logic [RADIX_W-1:0]  radix;
      logic [LENGTH_W-1:0] len;
      logic [AMOUNT_W-1:0] amt;
      logic [CMD_W-1:0]    op;

      //   kind       cmd       amount        idx    sym    radix   len    event      lsd
      row(ROW_REQ,   CMD_LOAD, 32'd0,        8'd0,  8'hff, 9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_REQ,   CMD_LOAD, 32'hffffffff, 8'hff, 8'h00, 9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_KNOWN, CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_KNOWN, CMD_ADD,  32'd1,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd1);
      row(ROW_KNOWN, CMD_ADD,  32'd1,        8'd0,  8'd0,  9'd0,   5'd0,  EV_WRAP,   8'd0);
      row(ROW_KNOWN, CMD_SUB,  32'd1,        8'd0,  8'd0,  9'd0,   5'd0,  EV_STOP,   8'd0);
      row(ROW_KNOWN, CMD_ADD,  32'hffffffff, 8'd0,  8'd0,  9'd0,   5'd0,  EV_WRAP,   8'd1);
      row(ROW_KNOWN, CMD_SUB,  32'd1,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_REQ,   CMD_NONE, 32'hffffffff, 8'hff, 8'hff, 9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_CSR,   CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd256, 5'd16, EV_NORMAL, 8'd0);
      row(ROW_REQ,   CMD_ADD,  32'hffffffff, 8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_REQ,   CMD_ADD,  32'd1,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_REQ,   CMD_SUB,  32'hffffffff, 8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_KNOWN, CMD_SUB,  32'd2,        8'd0,  8'd0,  9'd0,   5'd0,  EV_STOP,   8'd0);
      row(ROW_CSR,   CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd1,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_KNOWN, CMD_ADD,  32'd5,        8'd0,  8'd0,  9'd0,   5'd0,  EV_WRAP,   8'd0);
      row(ROW_KNOWN, CMD_SUB,  32'd0,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_KNOWN, CMD_SUB,  32'd3,        8'd0,  8'd0,  9'd0,   5'd0,  EV_STOP,   8'd0);
      row(ROW_CSR,   CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd0,   5'd31, EV_NORMAL, 8'd0);
      row(ROW_KNOWN, CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_CSR,   CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd511, 5'd3,  EV_NORMAL, 8'd0);
      row(ROW_KNOWN, CMD_ADD,  32'h00ffffff, 8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'hff);
      row(ROW_CSR,   CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd10,  5'd3,  EV_NORMAL, 8'd0);
      row(ROW_KNOWN, CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd5);
      row(ROW_CSR,   CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd10,  5'd2,  EV_NORMAL, 8'd0);
      row(ROW_REQ,   CMD_ADD,  32'd7,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_CSR,   CMD_ADD,  32'd0,        8'd0,  8'd0,  9'd10,  5'd3,  EV_NORMAL, 8'd0);
      row(ROW_REQ,   CMD_SUB,  32'd9,        8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);
      row(ROW_REQ,   CMD_ADD,  32'hdeadbeef, 8'd0,  8'd0,  9'd0,   5'd0,  EV_NORMAL, 8'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole alphabet first so no digit can ever read an unloaded entry
      for (int i = 0; i < NUM_SYMBOLS; i++)
         issue_request(CMD_LOAD, $urandom, 8'(i), 8'($urandom_range(0, 255)), 1'b0,
                       EV_NORMAL, '0);

      foreach (drill_rows[i]) begin
         case (drill_rows[i].kind)
            ROW_CSR: begin
               wait_idle();
               write_config(drill_rows[i].radix, drill_rows[i].len);
            end
            default: begin
               issue_request(drill_rows[i].cmd, drill_rows[i].amount, drill_rows[i].idx,
                             drill_rows[i].sym, drill_rows[i].kind == ROW_KNOWN,
                             drill_rows[i].ev, drill_rows[i].lsd);
            end
         endcase
      end

      sent = 0;
      while (sent < 150) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0:       radix = RADIX_W'($urandom_range(1, 4));
            1:       radix = RADIX_W'($urandom_range(2, 16));
            2:       radix = 9'd256;
            3:       radix = RADIX_W'($urandom_range(0, 511));
            default: radix = RADIX_W'($urandom_range(2, 40));
         endcase
         case ($urandom_range(0, 4))
            0:       len = 5'd16;
            1:       len = LENGTH_W'($urandom_range(0, 31));
            default: len = LENGTH_W'($urandom_range(1, 4));
         endcase
         write_config(radix, len);
         rv = radix_used();
         phase_items = $urandom_range(4, 24);
         for (int n = 0; n < phase_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               issue_request(CMD_LOAD, $urandom, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 1'b0, EV_NORMAL, '0);
               sent++;
            end else if (pick < 11) begin
               issue_request(CMD_NONE, $urandom, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 1'b0, EV_NORMAL, '0);
            end else begin
               op = ($urandom_range(0, 99) < 60) ? CMD_ADD : CMD_SUB;
               case ($urandom_range(0, 4))
                  0:       amt = $urandom;
                  1:       amt = ($urandom_range(0, 1) != 0) ? 32'hffffffff : 32'd0;
                  2:       amt = $urandom_range(0, 1000);
                  default: amt = $urandom_range(0, 2 * rv * rv);
               endcase
               issue_request(op, amt, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'b0, EV_NORMAL, '0);
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/aoc_pkg.sv
rtl/core/aoc_div.sv
rtl/core/aoc_table.sv
rtl/core/alphabet_odometer_counter_top.sv
verif/tb_alphabet_odometer_counter_top.sv
